[hw/rtl/sparse_table_range_min_core_macros.svh]
// Assertion macros for the sparse-table range-minimum core.
`ifndef SPARSE_TABLE_RANGE_MIN_CORE_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define STRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in the range-minimum core.");

`define STRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed in the range-minimum core.");

`else

`define STRM_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define STRM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/strm_pkg.sv]
// Package with the sizes, codes and helper functions of the range-minimum core.
`timescale 1ns / 1ps

package strm_pkg;

    localparam int MAX_ELEMS  = 1024;
    localparam int NUM_LEVELS = 11;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int LVL_W  = 4;
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int MEM_DEPTH = NUM_LEVELS * MAX_ELEMS;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_B_RD,
        S_B_WR,
        S_Q_CMP
    } t_state;

    // Priority encoder: index of the highest set bit, zero for zero.
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        logic [LVL_W-1:0] k;
        k = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (x[b]) begin
                k = LVL_W'(b);
            end
        end
        return k;
    endfunction

endpackage

[hw/rtl/sparse_table_range_min_core.sv]
// Top level of the sparse-table range-minimum core with its table memory.
`timescale 1ns / 1ps

// The core keeps an 11-level sparse table of signed 32-bit values in one
// synchronous memory with one write port and two read ports. A load
// transaction writes a level-0 entry. In a query, both power-of-two
// windows are read from the table memory in the accept cycle and compared
// in the next; the result waits until the output register is free and is
// then held there until taken. A build with count n fills, for each level
// j >= 1 with 2^j <= n, the n - 2^j + 1 entries of that level, each read
// in S_B_RD and written in S_B_WR; no input is taken meanwhile. Table
// contents are undefined until loaded, so no clearing pass follows reset.
module sparse_table_range_min_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // elem_index[9:0], elem_value[41:10], elem_count[52:42],
    // range_left[62:53], range_right[72:63], zeros above.
    input  logic [strm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // operation[1:0].
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // range_min[31:0].
    output logic [strm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // status[0].
    output logic [0:0]                      o_m_tuser
);
    import strm_pkg::*;

    `include "sparse_table_range_min_core_macros.svh"

    logic signed [VALUE_BITS-1:0] r_mem [0:MEM_DEPTH-1];
    logic signed [VALUE_BITS-1:0] r_rd_a;
    logic signed [VALUE_BITS-1:0] r_rd_b;

    t_state             r_state, n_state;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_table_len, n_table_len;
    logic               r_q_err, n_q_err;
    logic               r_out_valid, n_out_valid;
    logic signed [VALUE_BITS-1:0] r_out_min, n_out_min;
    logic               r_out_err, n_out_err;

    logic                     w_acc;
    t_op                      w_op;
    logic [IDX_W-1:0]         w_elem_index;
    logic signed [VALUE_BITS-1:0] w_elem_value;
    logic [CNT_W-1:0]         w_elem_count;
    logic [IDX_W-1:0]         w_left;
    logic [IDX_W-1:0]         w_right;

    logic [CNT_W-1:0]         w_span;
    logic [LVL_W-1:0]         w_k;
    logic [CNT_W-1:0]         w_rb;
    logic                     w_qerr;
    logic [CNT_W-1:0]         w_count_sat;

    logic [CNT_W-1:0]         w_half;
    logic [CNT_W:0]           w_wid;
    logic [CNT_W:0]           w_wid_next;
    logic [LVL_W-1:0]         w_lvl_below;
    logic signed [VALUE_BITS-1:0] w_min;

    logic                     w_rd_en;
    logic [ADDR_W-1:0]        w_rd_addr_a;
    logic [ADDR_W-1:0]        w_rd_addr_b;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic signed [VALUE_BITS-1:0] w_wr_data;

    assign w_acc        = i_s_tvalid && o_s_tready;
    assign w_op         = t_op'(i_s_tuser);
    assign w_elem_index = i_s_tdata[9:0];
    assign w_elem_value = i_s_tdata[41:10];
    assign w_elem_count = i_s_tdata[52:42];
    assign w_left       = i_s_tdata[62:53];
    assign w_right      = i_s_tdata[72:63];

    assign w_span  = {1'b0, w_right} - {1'b0, w_left} + CNT_W'(1);
    assign w_k     = floor_log2(w_span);
    assign w_rb    = {1'b0, w_right} + CNT_W'(1) - (CNT_W'(1) << w_k);
    assign w_qerr  = (w_left > w_right) || ({1'b0, w_right} >= r_table_len);
    assign w_count_sat = (w_elem_count > CNT_W'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS)
                                                            : w_elem_count;

    assign w_lvl_below = r_lvl - LVL_W'(1);
    assign w_half      = CNT_W'(1) << w_lvl_below;
    assign w_wid       = (CNT_W+1)'(1) << r_lvl;
    assign w_wid_next  = (CNT_W+1)'(1) << (r_lvl + LVL_W'(1));
    assign w_min       = (r_rd_b < r_rd_a) ? r_rd_b : r_rd_a;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_min;
    assign o_m_tuser  = r_out_err;

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_table_len = r_table_len;
        n_q_err     = r_q_err;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_min   = r_out_min;
        n_out_err   = r_out_err;
        w_rd_en     = 1'b0;
        w_rd_addr_a = {w_lvl_below, r_idx};
        w_rd_addr_b = {w_lvl_below, r_idx + w_half[IDX_W-1:0]};
        w_we        = 1'b0;
        w_wr_addr   = {r_lvl, r_idx};
        w_wr_data   = w_min;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (w_op)
                        OP_LOAD: begin
                            w_we      = 1'b1;
                            w_wr_addr = {LVL_W'(0), w_elem_index};
                            w_wr_data = w_elem_value;
                        end
                        OP_BUILD: begin
                            n_table_len = w_count_sat;
                            n_cnt       = w_count_sat;
                            n_lvl       = LVL_W'(1);
                            n_idx       = '0;
                            if (w_count_sat >= CNT_W'(2)) begin
                                n_state = S_B_RD;
                            end
                        end
                        OP_QUERY: begin
                            w_rd_en     = 1'b1;
                            w_rd_addr_a = {w_k, w_left};
                            w_rd_addr_b = {w_k, w_rb[IDX_W-1:0]};
                            n_q_err     = w_qerr;
                            n_state     = S_Q_CMP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_B_RD: begin
                w_rd_en = 1'b1;
                n_state = S_B_WR;
            end
            S_B_WR: begin
                w_we = 1'b1;
                if ((CNT_W+1)'(r_idx) + (CNT_W+1)'(1) + w_wid <= (CNT_W+1)'(r_cnt)) begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_B_RD;
                end else if ((r_lvl < LVL_W'(NUM_LEVELS - 1)) &&
                             (w_wid_next <= (CNT_W+1)'(r_cnt))) begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_idx   = '0;
                    n_state = S_B_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_Q_CMP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_min   = r_q_err ? '0 : w_min;
                    n_out_err   = r_q_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_a <= r_mem[w_rd_addr_a];
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_table_len <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_table_len <= n_table_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl     <= n_lvl;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_q_err   <= n_q_err;
        r_out_min <= n_out_min;
        r_out_err <= n_out_err;
    end

    `STRM_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == '0)
    `STRM_ASSERT_NEXT(a_query_cmp, i_clk, i_rst_n, w_acc && (w_op == OP_QUERY), r_state == S_Q_CMP)
    `STRM_ASSERT_SAME(a_build_lvl, i_clk, i_rst_n, r_state == S_B_WR, (r_lvl != '0) && (r_lvl < LVL_W'(NUM_LEVELS)))
    `STRM_ASSERT_SAME(a_build_span, i_clk, i_rst_n, r_state == S_B_RD, (CNT_W+1)'(r_idx) + w_wid <= (CNT_W+1)'(r_cnt))

endmodule

[bench/sparse_table_range_min_check.sv]
`timescale 1ns / 1ps
// Checker for the range-minimum core: tracks the sparse table and compares each query answer.
module sparse_table_range_min_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // elem_index[9:0], elem_value[41:10], elem_count[52:42],
    // range_left[62:53], range_right[72:63], zeros above.
    input  logic [strm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // operation[1:0].
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // range_min[31:0].
    input  logic [strm_pkg::M_TDATA_W-1:0]  i_m_tdata,
    // status[0].
    input  logic [0:0]                      i_m_tuser,
    output int                              o_fail_count,
    output int                              o_pending
);
    import strm_pkg::*;

    typedef struct packed {
        logic signed [31:0] range_min;
        logic               status;
    } t_answer;

    logic signed [VALUE_BITS-1:0] levels [NUM_LEVELS][MAX_ELEMS];
    int                           built_len;
    t_answer                      answer_q [$];
    int                           mismatches = 0;

    task automatic fold_levels(input int count);
        int half;
        for (int j = 1; j < NUM_LEVELS; j++) begin
            half = 1 << (j - 1);
            for (int i = 0; i + (1 << j) <= count; i++) begin
                if (levels[j-1][i+half] < levels[j-1][i]) begin
                    levels[j][i] = levels[j-1][i+half];
                end else begin
                    levels[j][i] = levels[j-1][i];
                end
            end
        end
    endtask

    function automatic t_answer answer_for(input int left, input int right);
        t_answer                      a;
        int                           span;
        int                           lvl;
        logic signed [VALUE_BITS-1:0] lo_win;
        logic signed [VALUE_BITS-1:0] hi_win;
        if (left > right || right >= built_len) begin
            a.range_min = '0;
            a.status    = 1'b1;
            return a;
        end
        span = right - left + 1;
        lvl  = 0;
        for (int b = 0; b < 32; b++) begin
            if (span[b]) begin
                lvl = b;
            end
        end
        if (lvl > NUM_LEVELS - 1) begin
            lvl = NUM_LEVELS - 1;
        end
        lo_win = levels[lvl][left];
        hi_win = levels[lvl][right + 1 - (1 << lvl)];
        a.range_min = (hi_win < lo_win) ? hi_win[31:0] : lo_win[31:0];
        a.status    = 1'b0;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        int      count;
        if (!i_rst_n) begin
            built_len = 0;
            answer_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    $error("Result with no query pending: range_min %0d, status %0d",
                           $signed(i_m_tdata), i_m_tuser[0]);
                end else begin
                    want = answer_q.pop_front();
                    if (i_m_tdata !== want.range_min) begin
                        mismatches++;
                        $error("range_min: expected %0d, got %0d",
                               want.range_min, $signed(i_m_tdata));
                    end
                    if (i_m_tuser[0] !== want.status) begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", want.status, i_m_tuser[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    OP_LOAD: begin
                        levels[0][i_s_tdata[9:0]] = i_s_tdata[41:10];
                    end
                    OP_BUILD: begin
                        count = int'(i_s_tdata[52:42]);
                        if (count > MAX_ELEMS) begin
                            count = MAX_ELEMS;
                        end
                        built_len = count;
                        fold_levels(count);
                    end
                    OP_QUERY: begin
                        answer_q.push_back(answer_for(int'(i_s_tdata[62:53]),
                                                      int'(i_s_tdata[72:63])));
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= answer_q.size();
        o_fail_count <= mismatches;
    end

endmodule

[bench/sparse_table_range_min_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the range-minimum core: clock, reset, stimulus, watchdog and verdict.
module sparse_table_range_min_core_tb;
    import strm_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         STALL_LIMIT   = 100000;
    localparam int         PHASE_ITEMS   = 250;
    localparam int         SETTLE_CYCLES = 20;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    int                   fail_count;
    int                   pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int holds_done     = 0;
    bit loaded [MAX_ELEMS];
    int loaded_prefix  = 0;
    int built_len      = 0;
    int items_sent     = 0;

    always #1 clk = ~clk;

    sparse_table_range_min_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    sparse_table_range_min_check result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5, 6: return 32'($urandom_range(200)) - 32'd100;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_payload();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return {{(S_TDATA_W - 73){1'b0}}, r[72:0]};
    endfunction

    task automatic offer_item(input logic [1:0] op, input logic [S_TDATA_W-1:0] payload);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic load_elem(input int idx, input logic [31:0] value);
        logic [S_TDATA_W-1:0] payload;
        payload        = random_payload();
        payload[9:0]   = idx[9:0];
        payload[41:10] = value;
        offer_item(OP_LOAD, payload);
        loaded[idx] = 1'b1;
        while (loaded_prefix < MAX_ELEMS && loaded[loaded_prefix]) begin
            loaded_prefix++;
        end
        items_sent++;
    endtask

    task automatic build_table(input int count);
        logic [S_TDATA_W-1:0] payload;
        payload        = random_payload();
        payload[52:42] = count[10:0];
        offer_item(OP_BUILD, payload);
        built_len = (count > MAX_ELEMS) ? MAX_ELEMS : count;
        items_sent++;
    endtask

    task automatic query_range(input int left, input int right);
        logic [S_TDATA_W-1:0] payload;
        payload        = random_payload();
        payload[62:53] = left[9:0];
        payload[72:63] = right[9:0];
        offer_item(OP_QUERY, payload);
        items_sent++;
    endtask

    task automatic noise_item();
        offer_item(OP_UNUSED, random_payload());
    endtask

    task automatic random_query();
        int left;
        int right;
        if (built_len == 0 || $urandom_range(99) < 15) begin
            if (built_len < MAX_ELEMS && $urandom_range(1) == 1) begin
                right = $urandom_range(MAX_ELEMS - 1, built_len);
                left  = $urandom_range(right);
            end else begin
                right = $urandom_range(MAX_ELEMS - 2);
                left  = $urandom_range(MAX_ELEMS - 1, right + 1);
            end
        end else begin
            right = $urandom_range(built_len - 1);
            case ($urandom_range(3))
                0: left = right;
                1: left = 0;
                default: left = $urandom_range(right);
            endcase
        end
        query_range(left, right);
    endtask

    task automatic random_episode();
        int count;
        repeat ($urandom_range(12, 1)) begin
            if (loaded_prefix < MAX_ELEMS && $urandom_range(99) < 70) begin
                load_elem(loaded_prefix, pick_value());
            end else begin
                load_elem($urandom_range(MAX_ELEMS - 1), pick_value());
            end
        end
        if ($urandom_range(99) < 20) begin
            count = loaded_prefix;
        end else begin
            count = $urandom_range((loaded_prefix < 40) ? loaded_prefix : 40);
        end
        build_table(count);
        repeat ($urandom_range(10, 2)) begin
            random_query();
        end
        if ($urandom_range(99) < 5) begin
            noise_item();
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int first;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS) begin
            random_episode();
        end
        wait_drained();
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_reqs) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holds_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing built yet, so the first query must be rejected.
        query_range(0, 0);
        noise_item();
        load_elem(0, 32'h7FFF_FFFF);
        load_elem(1, 32'hFFFF_FFFF);
        load_elem(2, 32'h0000_0000);
        load_elem(3, 32'h0000_0001);
        load_elem(4, 32'hFFFF_FFFB);
        load_elem(5, 32'h7FFF_FFFE);
        load_elem(6, 32'h8000_0000);
        load_elem(7, 32'd12);
        load_elem(MAX_ELEMS - 1, 32'h5A5A_A5A5);
        build_table(0);
        query_range(0, 0);
        build_table(8);
        query_range(0, 7);
        query_range(3, 3);
        query_range(1, 4);
        query_range(0, 5);
        query_range(5, 2);
        query_range(0, 8);
        query_range(7, 7);
        // Upper levels stay stale after a load until the next build.
        load_elem(4, 32'd100);
        query_range(1, 4);
        build_table(1);
        query_range(0, 0);
        query_range(0, 1);
        wait_drained();

        run_phase(0, 0);
        hold_reqs++;
        repeat (16) begin
            random_query();
        end
        wait_drained();
        run_phase(83, 0);
        run_phase(0, 83);
        run_phase(25, 25);

        while (loaded_prefix < MAX_ELEMS) begin
            load_elem(loaded_prefix, pick_value());
        end
        build_table(MAX_ELEMS);
        query_range(0, MAX_ELEMS - 1);
        query_range(0, 0);
        query_range(MAX_ELEMS - 1, MAX_ELEMS - 1);
        query_range(1, MAX_ELEMS - 2);
        repeat (20) begin
            random_query();
        end
        build_table($urandom_range(2047, MAX_ELEMS + 1));
        query_range(0, MAX_ELEMS - 1);
        repeat (20) begin
            random_query();
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sparse_table_range_min_core.f]
+incdir+hw/rtl
hw/rtl/strm_pkg.sv
hw/rtl/sparse_table_range_min_core.sv
bench/sparse_table_range_min_check.sv
bench/sparse_table_range_min_core_tb.sv
